// ===== design/assert_macros.svh =====
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== design/bpa_pkg.sv =====
package bpa_pkg;

  localparam int ORD_W  = 4;
  localparam int IDX_W  = 12;
  localparam int STAT_W = 2;
  localparam int MODE_W = 2;
  localparam int CNT_W  = 13;

  localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEED  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADORD  = 2'd2;

  typedef enum logic [2:0] {
    K_NOP   = 3'd0,
    K_ERR   = 3'd1,
    K_ALLOC = 3'd2,
    K_FREE  = 3'd3,
    K_SEED  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ORD_W-1:0]   order;
    logic [IDX_W-1:0]   idx;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

// ===== design/bpa_if.sv =====
interface bpa_in_if;
  logic                      valid;
  logic                      ready;
  logic [bpa_pkg::MODE_W-1:0] mode;
  logic [bpa_pkg::ORD_W-1:0]  order;
  logic [bpa_pkg::IDX_W-1:0]  first_page;

  modport source (output valid, output mode, output order, output first_page, input ready);
  modport sink (input valid, input mode, input order, input first_page, output ready);
endinterface

interface bpa_out_if;
  logic                       valid;
  logic                       ready;
  logic [bpa_pkg::STAT_W-1:0] status;
  logic [bpa_pkg::IDX_W-1:0]  granted_index;

  modport source (output valid, output status, output granted_index, input ready);
  modport sink (input valid, input status, input granted_index, output ready);
endinterface

// ===== design/bpa_front.sv =====
module bpa_front #(
  parameter int NUM_PAGES  = 4096,
  parameter int NUM_ORDERS = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  bpa_in_if.sink          in_ch,
  input  logic            hold,
  output logic            q_valid,
  output bpa_pkg::item_t  q_item,
  input  logic            q_pop
);

  localparam int QD = 2;

  bpa_pkg::item_t cls;
  bpa_pkg::item_t q_mem_r [QD];
  logic           wr_r, wr_nxt;
  logic           rd_r, rd_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           ord_bad;
  logic           idx_bad;

  // classify the incoming beat
  assign ord_bad = {1'b0, in_ch.order} >= 5'(NUM_ORDERS);
  assign idx_bad = int'(in_ch.first_page) >= NUM_PAGES;

  always_comb begin
    cls.order = in_ch.order;
    cls.idx   = in_ch.first_page;
    cls.kind  = bpa_pkg::K_NOP;
    if (in_ch.mode == bpa_pkg::MODE_NONE) begin
      cls.kind = bpa_pkg::K_NOP;
    end else if (ord_bad) begin
      cls.kind = bpa_pkg::K_ERR;
    end else begin
      unique case (in_ch.mode)
        bpa_pkg::MODE_ALLOC: cls.kind = bpa_pkg::K_ALLOC;
        bpa_pkg::MODE_FREE:  cls.kind = idx_bad ? bpa_pkg::K_NOP : bpa_pkg::K_FREE;
        bpa_pkg::MODE_SEED:  cls.kind = idx_bad ? bpa_pkg::K_NOP : bpa_pkg::K_SEED;
        default:             cls.kind = bpa_pkg::K_NOP;
      endcase
    end
  end

  // two-entry queue toward the back end
  assign in_ch.ready = (cnt_r != 2'(QD)) && !hold;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = cnt_r != 2'd0;
  assign q_item      = q_mem_r[rd_r];

  always_comb begin
    wr_nxt  = push  ? ~wr_r : wr_r;
    rd_nxt  = q_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/bpa_back.sv =====
module bpa_back #(
  parameter int NUM_PAGES  = 4096,
  parameter int NUM_ORDERS = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  bpa_pkg::item_t              q_item,
  output logic                        q_pop,
  input  logic [bpa_pkg::CNT_W-1:0]   page_count,
  bpa_out_if.source                   out_ch,
  output bpa_pkg::back_stat_t         stat
);

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int LKW = PW + 1;
  localparam int LW  = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int OW  = bpa_pkg::ORD_W;
  localparam int OFW = OW + 1;
  localparam int MW0 = (PW > NUM_ORDERS) ? PW : NUM_ORDERS;
  localparam int XW  = ((MW0 > bpa_pkg::CNT_W) ? MW0 : bpa_pkg::CNT_W) + 1;
  localparam int IW  = bpa_pkg::IDX_W;
  localparam logic [LKW-1:0] NIL = '1;

  typedef enum logic [11:0] {
    S_CLR    = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_SCAN   = 12'b000000000100,
    S_RD     = 12'b000000001000,
    S_EVAL   = 12'b000000010000,
    S_UNL2   = 12'b000000100000,
    S_SPLIT  = 12'b000001000000,
    S_FCHK   = 12'b000010000000,
    S_PUSH_A = 12'b000100000000,
    S_PUSH_B = 12'b001000000000,
    S_SEED   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  // page table: order with free mark, next link, prev link
  logic [OFW-1:0] of_mem [NUM_PAGES];
  logic [LKW-1:0] nx_mem [NUM_PAGES];
  logic [LKW-1:0] pv_mem [NUM_PAGES];
  logic [OFW-1:0] of_q;
  logic [LKW-1:0] nx_q, pv_q;

  logic           of_we, nx_we, pv_we;
  logic [PW-1:0]  of_wa, nx_wa, pv_wa;
  logic [OFW-1:0] of_wd;
  logic [LKW-1:0] nx_wd, pv_wd;

  logic [LKW-1:0] head_r [NUM_ORDERS];
  logic           head_we;
  logic [LKW-1:0] head_wd;
  logic [LKW-1:0] head_sel;

  state_t                     state_r, state_nxt;
  bpa_pkg::kind_t             kind_r, kind_nxt;
  logic [OW-1:0]              lvl_r, lvl_nxt;
  logic [OW-1:0]              ord_r, ord_nxt;
  logic [PW-1:0]              blk_r, blk_nxt;
  logic [PW-1:0]              pg_r, pg_nxt;
  logic [LKW-1:0]             h_r, h_nxt;
  logic [XW-1:0]              sp_r, sp_nxt;
  logic [XW-1:0]              end_r, end_nxt;
  logic [PW-1:0]              clr_r, clr_nxt;
  logic [bpa_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [IW-1:0]              grant_r, grant_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [bpa_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [IW-1:0]              out_grant_r, out_grant_nxt;

  logic [XW-1:0]    blk_x, bud_x, split_x, idx_x;
  logic [OW-1:0]    lvl_m1;
  logic [PW+IW-1:0] gx;

  assign head_sel = head_r[lvl_r[LW-1:0]];
  assign blk_x    = XW'(blk_r);
  assign bud_x    = blk_x ^ (XW'(1) << lvl_r);
  assign lvl_m1   = lvl_r - OW'(1);
  assign split_x  = blk_x + (XW'(1) << lvl_m1);
  assign idx_x    = XW'(q_item.idx);
  assign gx       = {{IW{1'b0}}, blk_r};

  // sequencer: one table access step per cycle
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    lvl_nxt        = lvl_r;
    ord_nxt        = ord_r;
    blk_nxt        = blk_r;
    pg_nxt         = pg_r;
    h_nxt          = h_r;
    sp_nxt         = sp_r;
    end_nxt        = end_r;
    clr_nxt        = clr_r;
    status_nxt     = status_r;
    grant_nxt      = grant_r;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    q_pop          = 1'b0;
    of_we          = 1'b0;
    nx_we          = 1'b0;
    pv_we          = 1'b0;
    of_wa          = pg_r;
    nx_wa          = pg_r;
    pv_wa          = pg_r;
    of_wd          = '0;
    nx_wd          = NIL;
    pv_wd          = NIL;
    head_we        = 1'b0;
    head_wd        = NIL;

    unique case (state_r)
      S_CLR: begin
        of_we   = 1'b1;
        nx_we   = 1'b1;
        pv_we   = 1'b1;
        of_wa   = clr_r;
        nx_wa   = clr_r;
        pv_wa   = clr_r;
        clr_nxt = clr_r + PW'(1);
        if (clr_r == PW'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          kind_nxt   = q_item.kind;
          ord_nxt    = q_item.order;
          lvl_nxt    = q_item.order;
          blk_nxt    = idx_x[PW-1:0];
          sp_nxt     = idx_x;
          end_nxt    = idx_x + (XW'(1) << q_item.order);
          status_nxt = bpa_pkg::ST_DONE;
          grant_nxt  = '0;
          case (q_item.kind)
            bpa_pkg::K_ERR: begin
              status_nxt = bpa_pkg::ST_BADORD;
              state_nxt  = S_DONE;
            end
            bpa_pkg::K_ALLOC: state_nxt = S_SCAN;
            bpa_pkg::K_FREE:  state_nxt = S_FCHK;
            bpa_pkg::K_SEED:  state_nxt = S_SEED;
            default:          state_nxt = S_DONE;
          endcase
        end
      end

      // look for the smallest non-empty list
      S_SCAN: begin
        if (!head_sel[LKW-1]) begin
          blk_nxt   = head_sel[PW-1:0];
          pg_nxt    = head_sel[PW-1:0];
          state_nxt = S_RD;
        end else if (lvl_r == OW'(NUM_ORDERS - 1)) begin
          status_nxt = bpa_pkg::ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          lvl_nxt = lvl_r + OW'(1);
        end
      end

      S_RD: state_nxt = S_EVAL;

      // on free, push the block if the buddy is not free; else drop the read block from its list
      S_EVAL: begin
        if (kind_r == bpa_pkg::K_FREE && !(of_q[OW] && of_q[OW-1:0] == lvl_r)) begin
          pg_nxt    = blk_r;
          state_nxt = S_PUSH_A;
        end else begin
          if (head_sel == {1'b0, pg_r}) begin
            head_we = 1'b1;
            head_wd = nx_q;
          end
          if (!pv_q[LKW-1]) begin
            nx_we = 1'b1;
            nx_wa = pv_q[PW-1:0];
            nx_wd = nx_q;
          end
          if (!nx_q[LKW-1]) begin
            pv_we = 1'b1;
            pv_wa = nx_q[PW-1:0];
            pv_wd = pv_q;
          end
          of_we     = 1'b1;
          of_wd     = {1'b0, of_q[OW-1:0]};
          state_nxt = S_UNL2;
        end
      end

      S_UNL2: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        if (kind_r == bpa_pkg::K_ALLOC) begin
          state_nxt = S_SPLIT;
        end else begin
          if (pg_r < blk_r) begin
            blk_nxt = pg_r;
          end
          lvl_nxt   = lvl_r + OW'(1);
          state_nxt = S_FCHK;
        end
      end

      // stop merging at the top order or at a buddy out of range
      S_FCHK: begin
        if (lvl_r >= OW'(NUM_ORDERS - 1) || bud_x >= XW'(page_count) ||
            bud_x >= XW'(NUM_PAGES)) begin
          pg_nxt    = blk_r;
          state_nxt = S_PUSH_A;
        end else begin
          pg_nxt    = bud_x[PW-1:0];
          state_nxt = S_RD;
        end
      end

      // push upper halves down to the requested order
      S_SPLIT: begin
        if (lvl_r > ord_r) begin
          lvl_nxt = lvl_m1;
          if (split_x < XW'(NUM_PAGES)) begin
            pg_nxt    = split_x[PW-1:0];
            state_nxt = S_PUSH_A;
          end
        end else begin
          of_we     = 1'b1;
          of_wa     = blk_r;
          of_wd     = {1'b0, ord_r};
          grant_nxt = gx[IW-1:0];
          state_nxt = S_DONE;
        end
      end

      S_PUSH_A: begin
        of_we     = 1'b1;
        of_wd     = {1'b1, lvl_r};
        nx_we     = 1'b1;
        nx_wd     = head_sel;
        pv_we     = 1'b1;
        head_we   = 1'b1;
        head_wd   = {1'b0, pg_r};
        h_nxt     = head_sel;
        state_nxt = S_PUSH_B;
      end

      S_PUSH_B: begin
        if (!h_r[LKW-1]) begin
          pv_we = 1'b1;
          pv_wa = h_r[PW-1:0];
          pv_wd = {1'b0, pg_r};
        end
        state_nxt = (kind_r == bpa_pkg::K_ALLOC) ? S_SPLIT : S_DONE;
      end

      // mark every page of the seeded block that lies below NUM_PAGES, then push the block
      S_SEED: begin
        if (sp_r < end_r && sp_r < XW'(NUM_PAGES)) begin
          of_we  = 1'b1;
          of_wa  = sp_r[PW-1:0];
          of_wd  = {1'b1, ord_r};
          sp_nxt = sp_r + XW'(1);
        end else begin
          pg_nxt    = blk_r;
          state_nxt = S_PUSH_A;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_grant_nxt  = grant_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // table memories
  always_ff @(posedge clk) begin
    if (of_we) begin
      of_mem[of_wa] <= of_wd;
    end
    of_q <= of_mem[pg_r];
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    nx_q <= nx_mem[pg_r];
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      pv_mem[pv_wa] <= pv_wd;
    end
    pv_q <= pv_mem[pg_r];
  end

  // list heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ORDERS; i++) begin
        head_r[i] <= NIL;
      end
    end else if (head_we) begin
      head_r[lvl_r[LW-1:0]] <= head_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    lvl_r        <= lvl_nxt;
    ord_r        <= ord_nxt;
    blk_r        <= blk_nxt;
    pg_r         <= pg_nxt;
    h_r          <= h_nxt;
    sp_r         <= sp_nxt;
    end_r        <= end_nxt;
    status_r     <= status_nxt;
    grant_r      <= grant_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.granted_index = out_grant_r;

  assign stat.clearing = (state_r == S_CLR);
  assign stat.busy     = (state_r != S_IDLE);

endmodule

// ===== design/buddy_page_allocator.sv =====
// Allocate scans orders upward, then splits, pushing each dropped half onto its list;
// free merges level by level until a buddy is refused; seed marks each page of the
// block; a bad order or no-op goes straight to the result, after queue entry.
// Throughput: one item at a time in the table sequencer, each table memory taking one
// write and one read per cycle; up to two items wait in the front queue.
// Reset: synchronous active-low; lists empty, then a pass over every page clears the
// page table, during which no item is accepted (page_count writes still taken).
module buddy_page_allocator #(
  parameter int NUM_PAGES  = 4096,
  parameter int NUM_ORDERS = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bpa_in_if.sink                    in_ch,
  bpa_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [bpa_pkg::CNT_W-1:0] cfg_wdata
);

  `include "assert_macros.svh"

  logic                      q_valid;
  logic                      q_pop;
  bpa_pkg::item_t            q_item;
  bpa_pkg::back_stat_t       bstat;
  logic [bpa_pkg::CNT_W-1:0] page_count_r, page_count_nxt;

  // hold the page count register
  assign page_count_nxt = cfg_we ? cfg_wdata : page_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= bpa_pkg::PAGE_COUNT_RST;
    end else begin
      page_count_r <= page_count_nxt;
    end
  end

  bpa_front #(
    .NUM_PAGES  (NUM_PAGES),
    .NUM_ORDERS (NUM_ORDERS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .hold    (bstat.clearing),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  bpa_back #(
    .NUM_PAGES  (NUM_PAGES),
    .NUM_ORDERS (NUM_ORDERS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .page_count (page_count_r),
    .out_ch     (out_ch),
    .stat       (bstat)
  );

  `ASSERT_NEVER(a_no_accept_clr, bstat.clearing && in_ch.valid && in_ch.ready, "beat taken during clear")
  `ASSERT_NEVER(a_no_pop_busy, q_pop && bstat.busy, "queue popped while sequencer busy")
  `ASSERT_CLK(a_grant_zero, out_ch.valid && out_ch.status != bpa_pkg::ST_DONE |-> out_ch.granted_index == '0, "grant set on failure")
  `ASSERT_CLK(a_clr_after_rst, !$past(rst_n) |-> bstat.clearing, "no clear pass after reset")

endmodule
